// ===== rtl/smss_pkg.sv =====
// ----------------------------------------------------------------------------
// smss_pkg
// Shared types and constants for the sorted matrix staircase search block.
// ----------------------------------------------------------------------------
package smss_pkg;

    // Field widths of the input, result and configuration transactions
    localparam int unsigned IDX_W     = 4;
    localparam int unsigned VALUE_W   = 32;
    localparam int unsigned COUNT_W   = 5;
    localparam int unsigned CFG_IDX_W = 8;

    typedef logic [IDX_W-1:0]           t_idx;
    typedef logic signed [VALUE_W-1:0]  t_value;
    typedef logic [COUNT_W-1:0]         t_count;
    typedef logic [CFG_IDX_W-1:0]       t_cfg_idx;

    // Transaction kinds
    typedef enum logic {
        KIND_WRITE  = 1'b0,
        KIND_SEARCH = 1'b1
    } t_kind;

    // Configuration register indexes
    localparam t_cfg_idx CFG_ROW_COUNT = t_cfg_idx'(0);
    localparam t_cfg_idx CFG_COL_COUNT = t_cfg_idx'(1);

    // Register reset values
    localparam t_count ROW_COUNT_RST = t_count'(3);
    localparam t_count COL_COUNT_RST = t_count'(3);

endpackage

// ===== rtl/smss_if.sv =====
// ----------------------------------------------------------------------------
// smss_if
// Handshake channels of the staircase search block: input items, results
// and configuration writes.
// ----------------------------------------------------------------------------

// Input transactions: matrix writes and searches
interface smss_in_if import smss_pkg::*; ();
    logic   valid;
    logic   ready;
    t_kind  kind;
    t_idx   row;
    t_idx   col;
    t_value entry_value;
    t_value search_key;

    modport source (output valid, kind, row, col, entry_value, search_key, input ready);
    modport sink   (input valid, kind, row, col, entry_value, search_key, output ready);
endinterface

// Result transactions, one per search
interface smss_out_if import smss_pkg::*; ();
    logic valid;
    logic ready;
    logic found;
    t_idx found_row;
    t_idx found_col;

    modport source (output valid, found, found_row, found_col, input ready);
    modport sink   (input valid, found, found_row, found_col, output ready);
endinterface

// Configuration register writes
interface smss_cfg_if import smss_pkg::*; ();
    logic     valid;
    logic     ready;
    t_cfg_idx index;
    t_count   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/smss_store.sv =====
// ----------------------------------------------------------------------------
// smss_store
// Matrix entry store: one write port and one read port, registered read data.
// ----------------------------------------------------------------------------
module smss_store import smss_pkg::*; #(
    parameter int unsigned DEPTH = 256,
    parameter int unsigned AW    = 8
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  t_value        i_wr_data,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output t_value        o_rd_data
);

    t_value r_mem [DEPTH];
    t_value r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port, registered read data
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/sorted_matrix_staircase_search.sv =====
// ----------------------------------------------------------------------------
// sorted_matrix_staircase_search
// Staircase search over a matrix with increasing rows and columns.
// ----------------------------------------------------------------------------
// A write transaction stores one entry in a single-port-read memory and
// completes in the cycle it is accepted; it gives no result. A search starts
// at the top-right corner of the used region and reads one entry per cycle,
// stepping down or left after each compare. The walk takes at most
// rows + cols - 1 steps, after which the S_DONE state loads the result
// register. A search holds the input off from its acceptance until its
// result is loaded, and that load waits while the output register still
// holds an earlier result that has not been taken. The memory read port,
// one read per step, paces the walk. Searches are handled one at a time;
// the input side is ready again once the result sits in the output
// register, even while it waits to be taken. The store is not cleared
// after reset: every entry in the used region must be written before a
// search reaches it.
// ----------------------------------------------------------------------------
module sorted_matrix_staircase_search import smss_pkg::*; #(
    parameter int unsigned MAX_ROWS = 16,
    parameter int unsigned MAX_COLS = 16
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    smss_in_if.sink    i_in,
    smss_out_if.source o_out,
    smss_cfg_if.sink   i_cfg
);

    localparam int unsigned DEPTH = MAX_ROWS * MAX_COLS;
    localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned XW    = $clog2(MAX_ROWS + 1);
    localparam int unsigned YW    = $clog2(MAX_COLS + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_DONE
    } t_state;

    // Registers
    t_state         r_state,     n_state;
    t_count         r_row_count, n_row_count;
    t_count         r_col_count, n_col_count;
    logic [XW-1:0]  r_x,         n_x;
    logic [XW-1:0]  r_rows,      n_rows;
    logic [YW-1:0]  r_ycnt,      n_ycnt;
    logic [AW-1:0]  r_addr,      n_addr;
    t_value         r_key,       n_key;
    logic           r_res_found, n_res_found;
    t_idx           r_res_row,   n_res_row;
    t_idx           r_res_col,   n_res_col;
    logic           r_out_valid, n_out_valid;
    logic           r_found,     n_found;
    t_idx           r_found_row, n_found_row;
    t_idx           r_found_col, n_found_col;

    // Store access
    logic           wr_en;
    logic [AW-1:0]  wr_addr;
    logic           rd_en;
    t_value         rd_data;

    // Helpers
    logic           in_fire;
    logic           cfg_fire;
    logic           wr_in_range;
    logic [XW-1:0]  rows_eff;
    logic [YW-1:0]  cols_eff;
    logic [XW-1:0]  x_inc;
    logic           out_free;

    assign in_fire  = i_in.valid & i_in.ready;
    assign cfg_fire = i_cfg.valid & i_cfg.ready;
    assign out_free = ~r_out_valid | o_out.ready;

    // Counts saturated to the store size
    assign rows_eff = ({27'b0, r_row_count} > 32'(MAX_ROWS)) ? XW'(MAX_ROWS)
                                                              : XW'(r_row_count);
    assign cols_eff = ({27'b0, r_col_count} > 32'(MAX_COLS)) ? YW'(MAX_COLS)
                                                              : YW'(r_col_count);
    assign x_inc    = r_x + XW'(1);

    // Entry writes outside the store are dropped
    assign wr_in_range = ({28'b0, i_in.row} < 32'(MAX_ROWS)) &&
                         ({28'b0, i_in.col} < 32'(MAX_COLS));
    assign wr_en   = in_fire && (i_in.kind == KIND_WRITE) && wr_in_range;
    assign wr_addr = AW'(32'(i_in.row) * 32'(MAX_COLS) + 32'(i_in.col));

    // Next state and walk step
    always_comb begin
        n_state     = r_state;
        n_row_count = r_row_count;
        n_col_count = r_col_count;
        n_x         = r_x;
        n_rows      = r_rows;
        n_ycnt      = r_ycnt;
        n_addr      = r_addr;
        n_key       = r_key;
        n_res_found = r_res_found;
        n_res_row   = r_res_row;
        n_res_col   = r_res_col;
        n_out_valid = r_out_valid & ~o_out.ready;
        n_found     = r_found;
        n_found_row = r_found_row;
        n_found_col = r_found_col;
        rd_en       = 1'b0;

        // Configuration writes, unknown indexes ignored
        if (cfg_fire) begin
            if (i_cfg.index == CFG_ROW_COUNT) begin
                n_row_count = i_cfg.data;
            end else if (i_cfg.index == CFG_COL_COUNT) begin
                n_col_count = i_cfg.data;
            end
        end

        case (r_state)
            S_IDLE: begin
                if (in_fire && (i_in.kind == KIND_SEARCH)) begin
                    n_key       = i_in.search_key;
                    n_rows      = rows_eff;
                    n_x         = '0;
                    n_ycnt      = cols_eff;
                    n_addr      = AW'(cols_eff - YW'(1));
                    n_res_found = 1'b0;
                    n_res_row   = '0;
                    n_res_col   = '0;
                    if ((rows_eff == '0) || (cols_eff == '0)) begin
                        n_state = S_DONE;
                    end else begin
                        rd_en   = 1'b1;
                        n_state = S_WALK;
                    end
                end
            end
            S_WALK: begin
                // rd_data holds the entry at (r_x, r_ycnt - 1)
                if (rd_data == r_key) begin
                    n_res_found = 1'b1;
                    n_res_row   = t_idx'(r_x);
                    n_res_col   = t_idx'(r_ycnt - YW'(1));
                    n_state     = S_DONE;
                end else if (rd_data < r_key) begin
                    // step down
                    n_x = x_inc;
                    if (x_inc == r_rows) begin
                        n_state = S_DONE;
                    end else begin
                        n_addr = r_addr + AW'(MAX_COLS);
                        rd_en  = 1'b1;
                    end
                end else begin
                    // step left
                    n_ycnt = r_ycnt - YW'(1);
                    if (r_ycnt == YW'(1)) begin
                        n_state = S_DONE;
                    end else begin
                        n_addr = r_addr - AW'(1);
                        rd_en  = 1'b1;
                    end
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_found     = r_res_found;
                    n_found_row = r_res_row;
                    n_found_col = r_res_col;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_row_count <= ROW_COUNT_RST;
            r_col_count <= COL_COUNT_RST;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_row_count <= n_row_count;
            r_col_count <= n_col_count;
            r_out_valid <= n_out_valid;
        end
        r_x         <= n_x;
        r_rows      <= n_rows;
        r_ycnt      <= n_ycnt;
        r_addr      <= n_addr;
        r_key       <= n_key;
        r_res_found <= n_res_found;
        r_res_row   <= n_res_row;
        r_res_col   <= n_res_col;
        r_found     <= n_found;
        r_found_row <= n_found_row;
        r_found_col <= n_found_col;
    end

    // Entry store
    smss_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (i_in.entry_value),
        .i_rd_en   (rd_en),
        .i_rd_addr (n_addr),
        .o_rd_data (rd_data)
    );

    // Channel outputs
    assign i_in.ready      = (r_state == S_IDLE);
    assign i_cfg.ready     = 1'b1;
    assign o_out.valid     = r_out_valid;
    assign o_out.found     = r_found;
    assign o_out.found_row = r_found_row;
    assign o_out.found_col = r_found_col;

endmodule

// ===== tb/sv/sorted_matrix_staircase_search_tb.sv =====
// ----------------------------------------------------------------------------
// sorted_matrix_staircase_search_tb
// Self-checking bench for the staircase search block. Sorted matrices are
// written through the input channel, then searched with keys that hit, miss
// and sit at the value extremes. A shadow copy of the store and the size
// registers predicts every search result, and each result transaction is
// checked field by field. Random idling on both channels, a long receiver
// hold-off and several matrix sizes (zero, oversized and full) are covered.
// ----------------------------------------------------------------------------
module sorted_matrix_staircase_search_tb;
    import smss_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_ROWS       = 16;
    localparam int MAX_COLS       = 16;
    localparam int SETTLE_CYCLES  = 40;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 3000;

    localparam t_value VMIN = 32'sh8000_0000;
    localparam t_value VMAX = 32'sh7FFF_FFFF;

    // Register indexes outside the list, which the block must ignore
    localparam t_cfg_idx CFG_SPARE_IDX = t_cfg_idx'(2);
    localparam t_cfg_idx CFG_LAST_IDX  = '1;

    typedef struct {
        t_kind  kind;
        t_idx   row;
        t_idx   col;
        t_value entry_value;
        t_value search_key;
    } t_matrix_op;

    typedef struct {
        logic found;
        t_idx row;
        t_idx col;
    } t_hit;

    logic i_clk = 1'b0;
    logic i_rst_n;

    smss_in_if  in_if ();
    smss_out_if out_if ();
    smss_cfg_if cfg_if ();

    sorted_matrix_staircase_search #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    // Shadow of the block state
    t_value mat_shadow [MAX_ROWS][MAX_COLS];
    bit     written    [MAX_ROWS][MAX_COLS];
    t_count rows_reg = ROW_COUNT_RST;
    t_count cols_reg = COL_COUNT_RST;

    t_hit pending_hits [$];
    int   mismatch_count  = 0;
    int   send_idle_pct   = 0;
    int   recv_idle_pct   = 0;
    int   hold_cycles_req = 0;
    int   hold_left       = 0;
    int   quiet_cycles    = 0;

    // Clock, 10 ns period
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int used_rows();
        return (rows_reg > MAX_ROWS) ? MAX_ROWS : int'(rows_reg);
    endfunction

    function automatic int used_cols();
        return (cols_reg > MAX_COLS) ? MAX_COLS : int'(cols_reg);
    endfunction

    // Walk from the top-right corner: down when below the key, left when above
    function automatic t_hit walk_staircase(input t_value key);
        t_hit h;
        int   x;
        int   y;
        int   rows;
        h    = '{found: 1'b0, row: '0, col: '0};
        rows = used_rows();
        x    = 0;
        y    = used_cols() - 1;
        while (x < rows && y >= 0) begin
            if (mat_shadow[x][y] < key) begin
                x++;
            end else if (mat_shadow[x][y] > key) begin
                y--;
            end else begin
                h.found = 1'b1;
                h.row   = t_idx'(x);
                h.col   = t_idx'(y);
                break;
            end
        end
        return h;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t ns  mismatch: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // One input transaction, with an optional gap in front of it
    task automatic send_item(input t_matrix_op op);
        int gap;
        if ($urandom_range(99) < send_idle_pct) begin
            gap = $urandom_range(1, 4);
            repeat (gap) begin
                @(negedge i_clk);
                in_if.valid <= 1'b0;
            end
        end
        @(negedge i_clk);
        in_if.valid       <= 1'b1;
        in_if.kind        <= op.kind;
        in_if.row         <= op.row;
        in_if.col         <= op.col;
        in_if.entry_value <= op.entry_value;
        in_if.search_key  <= op.search_key;
        do @(posedge i_clk); while (!in_if.ready);
        if (op.kind == KIND_WRITE) begin
            mat_shadow[op.row][op.col] = op.entry_value;
            written[op.row][op.col]    = 1'b1;
        end else begin
            pending_hits.push_back(walk_staircase(op.search_key));
        end
    endtask

    task automatic send_write(input int r, input int c, input t_value v);
        t_matrix_op op;
        op = '{kind: KIND_WRITE, row: t_idx'(r), col: t_idx'(c), entry_value: v,
               search_key: t_value'($urandom)};
        send_item(op);
    endtask

    task automatic send_search(input t_value key);
        t_matrix_op op;
        op = '{kind: KIND_SEARCH, row: t_idx'($urandom), col: t_idx'($urandom),
               entry_value: t_value'($urandom), search_key: key};
        send_item(op);
    endtask

    // Stop offering, let every result arrive and the block settle
    task automatic wait_idle();
        @(negedge i_clk);
        in_if.valid <= 1'b0;
        while (pending_hits.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input t_cfg_idx idx, input t_count value);
        @(negedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= value;
        do @(posedge i_clk); while (!cfg_if.ready);
        if (idx == CFG_ROW_COUNT) begin
            rows_reg = value;
        end else if (idx == CFG_COL_COUNT) begin
            cols_reg = value;
        end
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic set_size(input int r, input int c);
        wait_idle();
        write_register(CFG_ROW_COUNT, t_count'(r));
        write_register(CFG_COL_COUNT, t_count'(c));
    endtask

    // Key mix: mostly stored values, then near misses, random and extremes
    function automatic t_value pick_key();
        int     sel;
        t_value v;
        sel = $urandom_range(99);
        if (used_rows() == 0 || used_cols() == 0 || sel >= 80) begin
            case ($urandom_range(3))
                0:       return VMIN;
                1:       return VMAX;
                default: return t_value'($urandom);
            endcase
        end
        v = mat_shadow[$urandom_range(used_rows() - 1)][$urandom_range(used_cols() - 1)];
        if (sel < 55) begin
            return v;
        end
        return ($urandom_range(1) != 0) ? v + 1 : v - 1;
    endfunction

    // Write a fresh matrix, non-decreasing along rows and columns, row by row
    task automatic fill_sorted();
        longint grid [MAX_ROWS][MAX_COLS];
        longint prev;
        longint shift;
        int     rows;
        int     cols;
        int     anchor;
        rows   = used_rows();
        cols   = used_cols();
        anchor = $urandom_range(9);
        for (int r = 0; r < rows; r++) begin
            for (int c = 0; c < cols; c++) begin
                if (r == 0 && c == 0) begin
                    prev = (anchor == 0) ? longint'(VMIN) :
                           longint'($urandom_range(0, 32'hFFF0_0000)) - 64'sd2147483648;
                end else begin
                    prev = (r == 0) ? grid[r][c-1] :
                           (c == 0) ? grid[r-1][c] :
                           (grid[r-1][c] > grid[r][c-1]) ? grid[r-1][c] : grid[r][c-1];
                    prev += ($urandom_range(7) == 0) ? 0 : $urandom_range(1, 2000);
                end
                grid[r][c] = prev;
            end
        end
        // Sometimes pin the bottom-right corner to the largest value
        shift = (anchor == 1) ? longint'(VMAX) - grid[rows-1][cols-1] : 0;
        for (int r = 0; r < rows; r++) begin
            for (int c = 0; c < cols; c++) begin
                send_write(r, c, t_value'(grid[r][c] + shift));
            end
        end
    endtask

    // Set the size, fill the used region when needed, then mixed traffic
    task automatic run_phase(input int r, input int c, input int n_items, input bit refill);
        bit complete;
        set_size(r, c);
        complete = 1'b1;
        for (int x = 0; x < used_rows(); x++) begin
            for (int y = 0; y < used_cols(); y++) begin
                complete &= written[x][y];
            end
        end
        if (refill || !complete) begin
            fill_sorted();
        end
        repeat (n_items) begin
            if ($urandom_range(99) < 12) begin
                send_write($urandom_range(15), $urandom_range(15), t_value'($urandom));
            end else begin
                send_search(pick_key());
            end
        end
    endtask

    // Corners, extremes and misses on the 3 x 3 matrix left by reset
    task automatic test_directed_corners();
        t_value grid [3][3];
        grid = '{'{VMIN, -32'sd5, 32'sd0}, '{-32'sd4, 32'sd1, 32'sd100},
                 '{32'sd7, 32'sd200, VMAX}};
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                send_write(r, c, grid[r][c]);
            end
        end
        send_search(32'sd0);
        send_search(VMIN);
        send_search(VMAX);
        send_search(32'sd7);
        send_search(32'sd1);
        send_search(-32'sd5);
        send_search(32'sd2);
        send_search(32'sh8000_0001);
        send_search(32'sh7FFF_FFFE);
    endtask

    // Entries outside the used region are kept and become visible on growth
    task automatic test_outside_region_write();
        send_write(3, 0, 32'sd50);
        send_write(3, 1, 32'sd300);
        send_write(3, 2, VMAX);
        send_write(15, 15, t_value'($urandom));
        send_search(32'sd300);
        send_search(32'sd50);
        set_size(4, 3);
        send_search(32'sd300);
        send_search(32'sd50);
        send_search(VMAX);
        send_search(32'sd49);
    endtask

    // Writes to indexes off the register list leave the sizes alone
    task automatic test_out_of_list_registers();
        wait_idle();
        write_register(CFG_SPARE_IDX, t_count'(31));
        write_register(CFG_LAST_IDX, t_count'(0));
        repeat (6) send_search(pick_key());
    endtask

    // Any zero count means nothing can be found
    task automatic test_zero_counts();
        run_phase(0, 5, 5, 1'b0);
        run_phase(5, 0, 5, 1'b0);
        run_phase(0, 0, 3, 1'b0);
    endtask

    task automatic test_small_sizes();
        run_phase(1, 1, 10, 1'b1);
        run_phase(2, 5, 20, 1'b1);
        run_phase(5, 2, 20, 1'b1);
        run_phase(4, 4, 25, 1'b1);
    endtask

    task automatic test_full_size();
        run_phase(16, 16, 50, 1'b1);
    endtask

    // Counts above the store size saturate to it
    task automatic test_oversized_counts();
        run_phase(31, 17, 25, 1'b0);
        run_phase(16, 20, 15, 1'b0);
    endtask

    // Receiver holds off while searches keep coming, so the input stalls
    task automatic test_result_backpressure();
        wait_idle();
        hold_cycles_req = HOLD_CYCLES;
        repeat (8) send_search(pick_key());
        wait_idle();
    endtask

    // Random overwrites inside the region break the ordering
    task automatic test_unsorted_matrix();
        run_phase(6, 7, 0, 1'b1);
        repeat (20) send_write($urandom_range(5), $urandom_range(6), t_value'($urandom));
        repeat (30) send_search(pick_key());
    endtask

    task automatic test_wide_rows();
        run_phase(3, 16, 40, 1'b1);
    endtask

    // Result channel ready, with a counted hold-off on request
    always @(negedge i_clk) begin
        if (hold_cycles_req != 0) begin
            hold_left       = hold_cycles_req;
            hold_cycles_req = 0;
        end
        if (hold_left != 0) begin
            hold_left--;
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Check each result transaction against the oldest prediction
    always @(posedge i_clk) begin
        t_hit want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (pending_hits.size() == 0) begin
                report_mismatch($sformatf("result with none expected: found=%0b row=%0d col=%0d",
                                          out_if.found, out_if.found_row, out_if.found_col));
            end else begin
                want = pending_hits.pop_front();
                if (out_if.found !== want.found)
                    report_mismatch($sformatf("found got %0b want %0b",
                                              out_if.found, want.found));
                if (out_if.found_row !== want.row)
                    report_mismatch($sformatf("found_row got %0d want %0d",
                                              out_if.found_row, want.row));
                if (out_if.found_col !== want.col)
                    report_mismatch($sformatf("found_col got %0d want %0d",
                                              out_if.found_col, want.col));
            end
        end
    end

    // Watchdog: too long without any transaction on any channel
    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
            (cfg_if.valid && cfg_if.ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[sorted_matrix_staircase_search] ERROR");
            $finish;
        end
    end

    initial begin
        i_rst_n           = 1'b0;
        in_if.valid       = 1'b0;
        in_if.kind        = KIND_WRITE;
        in_if.row         = '0;
        in_if.col         = '0;
        in_if.entry_value = '0;
        in_if.search_key  = '0;
        out_if.ready      = 1'b0;
        cfg_if.valid      = 1'b0;
        cfg_if.index      = CFG_ROW_COUNT;
        cfg_if.data       = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Sender idles lightly, receiver heavily
        send_idle_pct = 14;
        recv_idle_pct = 56;
        test_directed_corners();
        test_outside_region_write();
        test_out_of_list_registers();
        test_zero_counts();
        test_small_sizes();

        // Roles swapped
        send_idle_pct = 56;
        recv_idle_pct = 14;
        test_full_size();
        test_oversized_counts();
        test_result_backpressure();

        // No idling
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_unsorted_matrix();
        test_wide_rows();

        wait_idle();
        if (mismatch_count == 0) begin
            $display("[sorted_matrix_staircase_search] OK");
        end else begin
            $display("[sorted_matrix_staircase_search] ERROR");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/smss_pkg.sv
rtl/smss_if.sv
rtl/smss_store.sv
rtl/sorted_matrix_staircase_search.sv
tb/sv/sorted_matrix_staircase_search_tb.sv
